// ===== design/assert_macros.svh =====
// Assertion macros for the box and triangle overlap test.
// Needs no other file; taken in by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BTO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bto_pkg.sv =====
// Types and constants for the box and triangle overlap test.
// Needs no other file.
package bto_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int HALF_WIDTH     = 31;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int PIPE_DEPTH     = 8;

   localparam logic [1:0] REG_HALF_X = 2'd0;
   localparam logic [1:0] REG_HALF_Y = 2'd1;
   localparam logic [1:0] REG_HALF_Z = 2'd2;
   localparam logic [1:0] REG_SKIP   = 2'd3;

   localparam logic [HALF_WIDTH-1:0] HALF_RESET = 31'd32768;

   // cyclic successors of an axis or a vertex
   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   typedef logic signed [FIELD_WIDTH-1:0] coord_field_type;

   typedef struct packed {
      coord_field_type cube_center_x;
      coord_field_type cube_center_y;
      coord_field_type cube_center_z;
      coord_field_type vert_a_x;
      coord_field_type vert_a_y;
      coord_field_type vert_a_z;
      coord_field_type vert_b_x;
      coord_field_type vert_b_y;
      coord_field_type vert_b_z;
      coord_field_type vert_c_x;
      coord_field_type vert_c_y;
      coord_field_type vert_c_z;
   } req_payload_type;

endpackage

// ===== design/bto_req_if.sv =====
// Request channel: one triangle and one box centre per transaction.
// Depends on bto_pkg.
interface bto_req_if
   import bto_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/bto_rsp_if.sv =====
// Response channel: one overlap bit per transaction.
// Depends on bto_pkg.
interface bto_rsp_if
   import bto_pkg::*;
();
   logic valid;
   logic ready;
   logic overlaps;

   modport source (output valid, output overlaps, input ready);
   modport sink   (input valid, input overlaps, output ready);
endinterface

// ===== design/box_triangle_overlap_test.sv =====
// Separating-axis triangle / box overlap test, eight-stage pipeline.
// Depends on bto_pkg, bto_req_if, bto_rsp_if and assert_macros.svh.
//
//   channel    direction  handshake               content
//   req_chan   in         valid/ready             box centre, three vertices
//   rsp_chan   out        valid/ready             overlaps
//   csr_*      in/out     APB write, pready high  half sizes, skip flag
//
// One transaction per cycle while the output is not stalled; each result
// passes through stages 0 to 7 before it is valid. The whole pipeline
// advances together and holds while the output register waits to be taken.
// Reset clears valid bits and loads the register defaults.
`include "assert_macros.svh"
module box_triangle_overlap_test
   import bto_pkg::*;
#(
   parameter int COORD_WIDTH = 32
)(
   input  logic                      clock,
   input  logic                      reset,
   bto_req_if.sink                   req_chan,
   bto_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int CW  = COORD_WIDTH;
   localparam int VW  = CW + 1;
   localparam int FW  = CW + 2;
   localparam int PW  = 2 * FW;
   localparam int NW  = PW + 1;
   localparam int LW  = CW + 3;
   localparam int HW  = NW - LW;
   localparam int BW  = (VW > 32) ? VW + 1 : 33;
   localparam int QPW = VW + FW;
   localparam int QW  = QPW + 1;
   localparam int RPW = HALF_WIDTH + FW;
   localparam int EW  = ((QW > FW + 33) ? QW : FW + 33) + 1;
   localparam int RTW = NW + HALF_WIDTH;
   localparam int RW  = NW + 33;
   localparam int SW  = (VW + NW + 3 > NW + 35) ? VW + NW + 3 : NW + 35;

   logic [HALF_WIDTH-1:0] h_ff [3];
   logic                  skip_ff;
   logic                  csr_wr;
   logic [1:0]            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= HALF_RESET;
         h_ff[1] <= HALF_RESET;
         h_ff[2] <= HALF_RESET;
         skip_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_HALF_X: h_ff[0] <= csr_pwdata[HALF_WIDTH-1:0];
            REG_HALF_Y: h_ff[1] <= csr_pwdata[HALF_WIDTH-1:0];
            REG_HALF_Z: h_ff[2] <= csr_pwdata[HALF_WIDTH-1:0];
            REG_SKIP:   skip_ff <= csr_pwdata[0];
            default:    skip_ff <= skip_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HALF_X: csr_prdata = {1'b0, h_ff[0]};
         REG_HALF_Y: csr_prdata = {1'b0, h_ff[1]};
         REG_HALF_Z: csr_prdata = {1'b0, h_ff[2]};
         REG_SKIP:   csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, skip_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;
   logic                  overlaps_ff;

   assign adv            = !vld_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_chan.overlaps = overlaps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_chan.valid};
      end
   end

   // input coordinates, centre first
   coord_field_type     fld    [12];
   logic signed [63:0]  fld_ext [12];
   logic signed [CW-1:0] vc    [12];

   assign fld[0]  = req_chan.payload.cube_center_x;
   assign fld[1]  = req_chan.payload.cube_center_y;
   assign fld[2]  = req_chan.payload.cube_center_z;
   assign fld[3]  = req_chan.payload.vert_a_x;
   assign fld[4]  = req_chan.payload.vert_a_y;
   assign fld[5]  = req_chan.payload.vert_a_z;
   assign fld[6]  = req_chan.payload.vert_b_x;
   assign fld[7]  = req_chan.payload.vert_b_y;
   assign fld[8]  = req_chan.payload.vert_b_z;
   assign fld[9]  = req_chan.payload.vert_c_x;
   assign fld[10] = req_chan.payload.vert_c_y;
   assign fld[11] = req_chan.payload.vert_c_z;

   always_comb begin
      for (int j = 0; j < 12; j++) begin
         fld_ext[j] = 64'($unsigned(fld[j]));
         vc[j]      = $signed(fld_ext[j][CW-1:0]);
      end
   end

   // stage 0: move to box-centred frame
   logic signed [VW-1:0] v0_ff [3][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               v0_ff[i][k] <= VW'(vc[3 + 3 * i + k]) - VW'(vc[k]);
            end
         end
      end
   end

   // stage 1: edges and box-face axes
   logic signed [VW-1:0] bmin [3];
   logic signed [VW-1:0] bmax [3];
   logic                 bsep_in;
   logic signed [VW-1:0] v1_ff [3][3];
   logic signed [FW-1:0] f1_ff [3][3];
   logic                 bsep1_ff;

   always_comb begin
      bsep_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         bmin[k] = v0_ff[0][k];
         bmax[k] = v0_ff[0][k];
         for (int i = 1; i < 3; i++) begin
            if (v0_ff[i][k] < bmin[k]) bmin[k] = v0_ff[i][k];
            if (v0_ff[i][k] > bmax[k]) bmax[k] = v0_ff[i][k];
         end
         if ($signed(BW'(bmin[k])) > $signed(BW'({1'b0, h_ff[k]})))
            bsep_in = 1'b1;
         if ($signed(BW'(bmax[k])) < -$signed(BW'({1'b0, h_ff[k]})))
            bsep_in = 1'b1;
      end
      bsep_in = bsep_in & !skip_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               v1_ff[i][k] <= v0_ff[i][k];
               f1_ff[i][k] <= FW'(v0_ff[NXT1[i]][k]) - FW'(v0_ff[i][k]);
            end
         end
         bsep1_ff <= bsep_in;
      end
   end

   // stage 2: all first-level products
   logic        [FW-1:0]  emag [3][3];
   logic signed [VW-1:0]  va2_ff [3];
   logic signed [PW-1:0]  np2_ff [3][2];
   logic signed [QPW-1:0] ep2_ff [3][3][4];
   logic        [RPW-1:0] rp2_ff [3][3][2];
   logic                  bsep2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            emag[i][k] = f1_ff[i][k][FW-1] ? FW'(-f1_ff[i][k]) : FW'(f1_ff[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            va2_ff[k]    <= v1_ff[0][k];
            np2_ff[k][0] <= f1_ff[0][NXT1[k]] * f1_ff[1][NXT2[k]];
            np2_ff[k][1] <= f1_ff[0][NXT2[k]] * f1_ff[1][NXT1[k]];
            for (int i = 0; i < 3; i++) begin
               ep2_ff[k][i][0] <= v1_ff[i][NXT2[k]] * f1_ff[i][NXT1[k]];
               ep2_ff[k][i][1] <= v1_ff[i][NXT1[k]] * f1_ff[i][NXT2[k]];
               ep2_ff[k][i][2] <= v1_ff[NXT2[i]][NXT2[k]] * f1_ff[i][NXT1[k]];
               ep2_ff[k][i][3] <= v1_ff[NXT2[i]][NXT1[k]] * f1_ff[i][NXT2[k]];
               rp2_ff[k][i][0] <= h_ff[NXT1[k]] * emag[i][NXT2[k]];
               rp2_ff[k][i][1] <= h_ff[NXT2[k]] * emag[i][NXT1[k]];
            end
         end
         bsep2_ff <= bsep1_ff;
      end
   end

   // stage 3: normal, edge projections and radii
   logic signed [VW-1:0] va3_ff [3];
   logic signed [NW-1:0] n3_ff  [3];
   logic signed [EW-1:0] q3_ff  [3][3][2];
   logic signed [EW-1:0] r3_ff  [3][3];
   logic                 bsep3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            va3_ff[k] <= va2_ff[k];
            n3_ff[k]  <= NW'(np2_ff[k][0]) - NW'(np2_ff[k][1]);
            for (int i = 0; i < 3; i++) begin
               q3_ff[k][i][0] <= EW'(ep2_ff[k][i][0]) - EW'(ep2_ff[k][i][1]);
               q3_ff[k][i][1] <= EW'(ep2_ff[k][i][2]) - EW'(ep2_ff[k][i][3]);
               r3_ff[k][i]    <= $signed(EW'(rp2_ff[k][i][0])) +
                                 $signed(EW'(rp2_ff[k][i][1]));
            end
         end
         bsep3_ff <= bsep2_ff;
      end
   end

   // stage 4: edge axis decisions, split plane products
   logic        [NW-1:0]      nmag  [3];
   logic                      esep_in;
   logic signed [VW+LW:0]     po4_lo_ff [3];
   logic signed [VW+HW-1:0]   po4_hi_ff [3];
   logic        [LW+HALF_WIDTH-1:0] pr4_lo_ff [3];
   logic        [HW+HALF_WIDTH-1:0] pr4_hi_ff [3];
   logic                      sep4_ff;

   always_comb begin
      esep_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         nmag[k] = n3_ff[k][NW-1] ? NW'(-n3_ff[k]) : NW'(n3_ff[k]);
         for (int i = 0; i < 3; i++) begin
            if ((q3_ff[k][i][0] > r3_ff[k][i] && q3_ff[k][i][1] > r3_ff[k][i]) ||
                (q3_ff[k][i][0] < -r3_ff[k][i] && q3_ff[k][i][1] < -r3_ff[k][i]))
               esep_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            po4_lo_ff[k] <= va3_ff[k] * $signed({1'b0, n3_ff[k][LW-1:0]});
            po4_hi_ff[k] <= va3_ff[k] * $signed(n3_ff[k][NW-1:LW]);
            pr4_lo_ff[k] <= nmag[k][LW-1:0] * h_ff[k];
            pr4_hi_ff[k] <= nmag[k][NW-1:LW] * h_ff[k];
         end
         sep4_ff <= bsep3_ff | esep_in;
      end
   end

   // stage 5: recombine split products
   logic signed [SW-1:0]  ot5_ff [3];
   logic        [RTW-1:0] rt5_ff [3];
   logic                  sep5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            ot5_ff[k] <= (SW'(po4_hi_ff[k]) <<< LW) + SW'(po4_lo_ff[k]);
            rt5_ff[k] <= (RTW'(pr4_hi_ff[k]) << LW) + RTW'(pr4_lo_ff[k]);
         end
         sep5_ff <= sep4_ff;
      end
   end

   // stage 6: plane offset and radius sums
   logic signed [SW-1:0] off6_ff;
   logic        [RW-1:0] rad6_ff;
   logic                 sep6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         off6_ff <= ot5_ff[0] + ot5_ff[1] + ot5_ff[2];
         rad6_ff <= RW'(rt5_ff[0]) + RW'(rt5_ff[1]) + RW'(rt5_ff[2]);
         sep6_ff <= sep5_ff;
      end
   end

   // stage 7: plane decision into the output register
   logic signed [SW-1:0] rad_s;
   logic                 overlaps_in;

   assign rad_s       = $signed(SW'(rad6_ff));
   assign overlaps_in = !(sep6_ff || off6_ff > rad_s || off6_ff < -rad_s);

   always_ff @(posedge clock) begin
      if (adv) begin
         overlaps_ff <= overlaps_in;
      end
   end

   `BTO_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "request taken while response stalled")
   `BTO_ASSERT_NXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[0], "accepted transaction missing from first stage")
   `BTO_ASSERT_NXT(a_stall_holds, clock, reset, !adv, $stable(vld_ff) && $stable(overlaps_ff), "pipeline moved during stall")

endmodule
